[rtl/tlpq_pkg.sv]
`timescale 1ns / 1ps
package tlpq_pkg;

  // Command codes carried in the cmd field
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [4:0]         CAP_RESET  = 5'd16;
  localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         priority_req;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         served_level;
    logic [1:0]         status;
  } out_item_t;

endpackage

[rtl/tlpq_ram.sv]
`timescale 1ns / 1ps
module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/three_level_priority_queue.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      in_item_i   (in_item_t)
// out       output     out_valid_o / out_stall_i    out_item_o  (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o    cfg_wdata_i (capacity_in_use)
//
// One item per cycle when not stalled; each result passes the read stage and output register.
// Pointers and fill counts sit in flops and update at accept; the entry RAM is
// written on a non-full enqueue, read on a non-empty dequeue at accept; data returns next cycle.
// Reset clears pointers, fill counts and capacity (16); the entry RAM is not cleared.
// A stalled output holds the output register, then the read stage, then the input.
module three_level_priority_queue
  import tlpq_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int LEVELS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_wdata_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > 5) ? FW : 5;
  localparam int LW = $clog2(LEVELS);
  localparam int RD = LEVELS * DEPTH;
  localparam int AW = $clog2(RD);

  logic [PW-1:0] head_q [LEVELS];
  logic [PW-1:0] head_d [LEVELS];
  logic [PW-1:0] tail_q [LEVELS];
  logic [PW-1:0] tail_d [LEVELS];
  logic [FW-1:0] fill_q [LEVELS];
  logic [FW-1:0] fill_d [LEVELS];
  logic [4:0]    cap_q;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_deq_q;
  out_item_t     s1_item_q, s1_item_d;
  logic          s1_adv;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q, out_item_d;

  logic          accept;
  logic          is_enq;
  logic [LW-1:0] enq_lvl;
  logic [LW-1:0] deq_lvl;
  logic          deq_found;
  logic          enq_full;
  logic [CW-1:0] eff_cap;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_enq     = (in_item_i.cmd == CMD_ENQUEUE);

  // saturate out-of-range levels to the lowest priority
  assign enq_lvl = (int'(in_item_i.priority_req) >= LEVELS) ?
                   LW'(LEVELS - 1) : LW'(in_item_i.priority_req);

  assign eff_cap  = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
  assign enq_full = CW'(fill_q[enq_lvl]) >= eff_cap;

  always_comb begin
    deq_found = 1'b0;
    deq_lvl   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        deq_found = 1'b1;
        deq_lvl   = LW'(l);
      end
    end
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = AW'(int'(enq_lvl) * DEPTH + int'(tail_q[enq_lvl]));
    ram_raddr  = AW'(int'(deq_lvl) * DEPTH + int'(head_q[deq_lvl]));
    s1_item_d  = s1_item_q;
    s1_valid_d = s1_valid_q && !s1_adv;
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_item_d.data_out = '0;
      s1_item_d.status   = STATUS_OK;
      if (is_enq) begin
        s1_item_d.served_level = 2'(enq_lvl);
        if (enq_full) begin
          s1_item_d.status = STATUS_FULL;
        end else begin
          ram_we          = 1'b1;
          tail_d[enq_lvl] = (int'(tail_q[enq_lvl]) == DEPTH - 1) ?
                            '0 : tail_q[enq_lvl] + 1'b1;
          fill_d[enq_lvl] = fill_q[enq_lvl] + 1'b1;
        end
      end else if (deq_found) begin
        ram_re                 = 1'b1;
        s1_item_d.served_level = 2'(deq_lvl);
        head_d[deq_lvl] = (int'(head_q[deq_lvl]) == DEPTH - 1) ?
                          '0 : head_q[deq_lvl] + 1'b1;
        fill_d[deq_lvl] = fill_q[deq_lvl] - 1'b1;
      end else begin
        s1_item_d.data_out     = EMPTY_DATA;
        s1_item_d.served_level = 2'd0;
        s1_item_d.status       = STATUS_EMPTY;
      end
    end
  end

  always_comb begin
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      out_valid_d = 1'b1;
      out_item_d  = s1_item_q;
      if (s1_deq_q) begin
        out_item_d.data_out = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        fill_q[l] <= '0;
      end
      cap_q       <= CAP_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q  <= s1_item_d;
    out_item_q <= out_item_d;
    if (accept) begin
      s1_deq_q <= ram_re;
    end
  end

  tlpq_ram #(
    .WIDTH(32),
    .DEPTH(RD)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_item_i.value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      int'(fill_q[g]) <= DEPTH)
      else $error("level fill exceeds ring depth");
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (fill_q[g] == '0) |-> (head_q[g] == tail_q[g]))
      else $error("empty level with head and tail apart");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("read stage lost an item under output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> $stable(ram_rdata))
    else $error("held dequeue data changed under stall");

endmodule

[bench/tb_three_level_priority_queue.sv]
`timescale 1ns / 1ps
module tb_three_level_priority_queue
  import tlpq_pkg::*;
();

  localparam int QDEPTH = 16;
  localparam int QLEVELS = 3;
  localparam logic [1:0] LVL_LOWEST = 2'd2;
  localparam logic [1:0] LVL_BAD = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 7;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [4:0] cfg_wdata_i;

  three_level_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the three rings
  logic signed [31:0] lvl_store [QLEVELS][QDEPTH];
  logic [3:0]         lvl_head [QLEVELS];
  logic [3:0]         lvl_tail [QLEVELS];
  logic [4:0]         lvl_fill [QLEVELS];
  logic [4:0]         capacity;

  out_item_t pending_results[$];
  dir_row_t  dir_table[$];
  out_item_t want_res;

  int errors = 0;
  int cycle_cnt = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding", $time, CYCLE_LIMIT,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Expected result of one item; advances the shadow rings
  function automatic out_item_t queue_model(in_item_t it);
    out_item_t  res;
    logic [1:0] lvl;
    logic [4:0] limit;
    bit         found;
    res.data_out = '0;
    res.served_level = '0;
    res.status = STATUS_OK;
    if (it.cmd == CMD_ENQUEUE) begin
      lvl = (it.priority_req >= QLEVELS) ? LVL_LOWEST : it.priority_req;
      limit = (capacity > QDEPTH) ? 5'(QDEPTH) : capacity;
      res.served_level = lvl;
      n_enq++;
      if (lvl_fill[lvl] >= limit) begin
        res.status = STATUS_FULL;
        n_full++;
      end else begin
        lvl_store[lvl][lvl_tail[lvl]] = it.value;
        lvl_tail[lvl] = 4'((lvl_tail[lvl] + 1) % QDEPTH);
        lvl_fill[lvl] = lvl_fill[lvl] + 1;
      end
    end else begin
      found = 0;
      n_deq++;
      for (int l = 0; l < QLEVELS; l++) begin
        if (!found && lvl_fill[l] != 0) begin
          res.data_out = lvl_store[l][lvl_head[l]];
          lvl_head[l] = 4'((lvl_head[l] + 1) % QDEPTH);
          lvl_fill[l] = lvl_fill[l] - 1;
          res.served_level = 2'(l);
          found = 1;
        end
      end
      if (!found) begin
        res.data_out = EMPTY_DATA;
        res.status = STATUS_EMPTY;
        n_empty++;
      end
    end
    return res;
  endfunction

  // Drive one item, hold it until accepted, then maybe idle
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = queue_model(it);
    pending_results.push_back(typed ? typed_res : predicted);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic write_capacity(logic [4:0] cap);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity = cap;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_row(logic cmd, logic [1:0] prio, logic signed [31:0] val,
                                  bit typed, logic signed [31:0] data, logic [1:0] lvl,
                                  logic [1:0] st);
    dir_row_t r;
    r.item.cmd = cmd;
    r.item.priority_req = prio;
    r.item.value = val;
    r.typed = typed;
    r.result.data_out = data;
    r.result.served_level = lvl;
    r.result.status = st;
    dir_table.push_back(r);
  endfunction

  function automatic in_item_t rand_item(int enq_pct);
    in_item_t it;
    it.cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
    it.priority_req = ($urandom_range(9) == 0) ? LVL_BAD : 2'($urandom_range(2));
    case ($urandom_range(7))
      0: it.value = 32'sh8000_0000;
      1: it.value = 32'sh7fff_ffff;
      2: it.value = -32'sd1;
      3: it.value = '0;
      default: it.value = $signed($urandom());
    endcase
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got data %0d level %0d status %0d",
                 $time, out_item_o.data_out, out_item_o.served_level, out_item_o.status);
        errors++;
      end else begin
        want_res = pending_results.pop_front();
        if (out_item_o.data_out !== want_res.data_out) begin
          $display("%0t: data_out expected %0d, got %0d", $time, want_res.data_out,
                   out_item_o.data_out);
          errors++;
        end
        if (out_item_o.served_level !== want_res.served_level) begin
          $display("%0t: served_level expected %0d, got %0d", $time, want_res.served_level,
                   out_item_o.served_level);
          errors++;
        end
        if (out_item_o.status !== want_res.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want_res.status,
                   out_item_o.status);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase_cap [NUM_PHASES];
    int sent;
    int len;
    int enq_pct;
    out_item_t no_res;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_wdata_i <= '0;
    no_res = '0;
    capacity = CAP_RESET;
    for (int l = 0; l < QLEVELS; l++) begin
      lvl_head[l] = '0;
      lvl_tail[l] = '0;
      lvl_fill[l] = '0;
    end

    // Empty after reset, value extremes, level saturation, priority order
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 1, EMPTY_DATA, 2'd0, STATUS_EMPTY);
    add_row(CMD_ENQUEUE, 2'd0, 32'sh7fff_ffff, 1, 32'sd0, 2'd0, STATUS_OK);
    add_row(CMD_ENQUEUE, 2'd1, 32'sh8000_0000, 1, 32'sd0, 2'd1, STATUS_OK);
    add_row(CMD_ENQUEUE, 2'd2, -32'sd1, 1, 32'sd0, 2'd2, STATUS_OK);
    add_row(CMD_ENQUEUE, LVL_BAD, 32'sd0, 1, 32'sd0, LVL_LOWEST, STATUS_OK);
    add_row(CMD_DEQUEUE, LVL_BAD, -32'sd1, 1, 32'sh7fff_ffff, 2'd0, STATUS_OK);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 1, 32'sh8000_0000, 2'd1, STATUS_OK);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 1, -32'sd1, 2'd2, STATUS_OK);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 1, 32'sd0, 2'd2, STATUS_OK);
    add_row(CMD_DEQUEUE, 2'd2, 32'sh5555_5555, 1, EMPTY_DATA, 2'd0, STATUS_EMPTY);
    add_row(CMD_ENQUEUE, 2'd2, 32'sh5555_5555, 0, '0, '0, '0);
    add_row(CMD_ENQUEUE, 2'd1, 32'sh2aaa_aaaa, 0, '0, '0, '0);
    add_row(CMD_ENQUEUE, 2'd1, -32'sd123456, 0, '0, '0, '0);
    add_row(CMD_ENQUEUE, 2'd0, 32'sd42, 0, '0, '0, '0);
    add_row(CMD_DEQUEUE, 2'd1, 32'sd0, 0, '0, '0, '0);
    add_row(CMD_ENQUEUE, 2'd0, 32'sd7, 0, '0, '0, '0);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 0, '0, '0, '0);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 0, '0, '0, '0);
    add_row(CMD_ENQUEUE, LVL_BAD, 32'shdead_beef, 0, '0, '0, '0);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 0, '0, '0, '0);
    add_row(CMD_DEQUEUE, 2'd0, 32'sd0, 0, '0, '0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].result);
    end

    // Zero and oversize limits, tiny rings, reset value, random settings; leave
    // entries in place so a lowered limit starts below the current fill
    phase_cap = '{31, 0, 3, 1, 16, $urandom_range(1, 16), $urandom_range(1, 31)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(5'(phase_cap[p]));
      case (p % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 75; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 75; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      sent = 0;
      while (sent < 58) begin
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
        len = $urandom_range(1, 14);
        for (int k = 0; k < len; k++) begin
          send_item(rand_item(enq_pct), 0, no_res);
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d enqueues (%0d rejected as full) and %0d dequeues (%0d on empty queues)",
             n_enq, n_full, n_deq, n_empty);
    $display("across %0d limit settings with idle and stall mixes up to 75 percent",
             NUM_PHASES + 1);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
